// File: hw/rtl/imsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_pkg
// Shared types, constants and helper functions of the Ising spin update
// block: command codes, controller command and status words, word layouts.
// ----------------------------------------------------------------------------
package imsu_pkg;

  localparam int LATTICE_SIDE_DEF = 32;
  localparam int NUM_REPLICAS_DEF = 16;

  localparam int REP_IN_W   = 4;
  localparam int REP_IN_N   = 2 ** REP_IN_W;
  localparam int SITE_W     = 10;
  localparam int FRAC_W     = 2 * SITE_W;
  localparam int PROB_W     = 16;
  localparam int DE_W       = 5;
  localparam int CNT_W      = 32;
  localparam int CNT_WORD_W = 3 * CNT_W;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    NBR_CENTER = 3'd0,
    NBR_UP     = 3'd1,
    NBR_DOWN   = 3'd2,
    NBR_LEFT   = 3'd3,
    NBR_RIGHT  = 3'd4
  } nbr_t;

  typedef struct packed {
    logic capture;
    logic spin_rd;
    logic spin_wr;
    logic cnt_rd;
    logic eval;
    logic cnt_clr;
    logic load_out;
    nbr_t nbr_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t op;
  } ctrl_sts_t;

  typedef logic [REP_IN_N-1:0][7:0] rep_tab_t;

  // replica index folding table, built by counting so no divider is needed
  function automatic rep_tab_t rep_table(input int n);
    rep_tab_t t;
    int c;
    c = 0;
    for (int i = 0; i < REP_IN_N; i++) begin
      t[i] = 8'(c);
      c = (c + 1 >= n) ? 0 : c + 1;
    end
    return t;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

// File: hw/rtl/ising_metropolis_spin_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis single spin flip for several periodic 2D Ising replicas, with
// saturating downhill, uphill and attempt counters per replica.
// ----------------------------------------------------------------------------
// One word is worked at a time, from accept to the next accept. The step
// time is set by the single-port lattice memory, which takes five spin reads
// and the write-back in series, after site and column reduction by constant
// reciprocal multiply in the S_DIV and S_MOD states. The next word is
// taken while the previous result still waits in the output register. The
// lattice is not cleared at reset and a spin must be written before a step
// reads it; the counters read as zero right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update
  import imsu_pkg::*;
#(
  parameter int LATTICE_SIDE = LATTICE_SIDE_DEF,
  parameter int NUM_REPLICAS = NUM_REPLICAS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // replica[3:0], site[13:4], spin_value[14], random_fraction[30:15],
  // threshold_four[46:31], threshold_eight[62:47], zero[63]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // new_spin[0], accepted[1], uphill[2], energy_change[7:3],
  // downhill_count[39:8], uphill_count[71:40], attempt_count[103:72]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  imsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  imsu_dp #(
    .LATTICE_SIDE (LATTICE_SIDE),
    .NUM_REPLICAS (NUM_REPLICAS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

// File: hw/rtl/imsu_cmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_cmod
// Remainder of a site index by a constant: reciprocal multiply, then one
// back-multiply and a single compare and subtract.
// ----------------------------------------------------------------------------
module imsu_cmod
  import imsu_pkg::*;
#(
  parameter int DIVISOR = LATTICE_SIDE_DEF
) (
  input  logic              clk,
  input  logic [SITE_W-1:0] x,
  output logic [SITE_W-1:0] rem
);

  localparam logic [FRAC_W-1:0] RECIP = FRAC_W'((1 << FRAC_W) / DIVISOR);
  localparam int DW = $clog2(DIVISOR + 1);
  localparam int QW = SITE_W + DW;

  logic [SITE_W+FRAC_W-1:0] prod_r;
  logic [SITE_W-1:0]        x_r;
  logic [SITE_W-1:0]        q0;
  logic [QW-1:0]            qd;
  logic [SITE_W-1:0]        r0;

  always_ff @(posedge clk) begin
    prod_r <= x * RECIP;
    x_r    <= x;
  end

  // estimate is exact or one low
  always_comb begin
    q0  = prod_r[SITE_W+FRAC_W-1:FRAC_W];
    qd  = QW'(q0) * QW'(DIVISOR);
    r0  = SITE_W'(QW'(x_r) - qd);
    rem = (QW'(r0) >= QW'(DIVISOR)) ? r0 - SITE_W'(DIVISOR) : r0;
  end

endmodule

// File: hw/rtl/imsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_ctrl
// Sequencer of the spin update block: accepts a word, steps the datapath
// through address reduction, lattice and counter accesses, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module imsu_ctrl
  import imsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_MOD  = 9'b000000100,
    S_WR   = 9'b000001000,
    S_RD   = 9'b000010000,
    S_EVAL = 9'b000100000,
    S_CRD  = 9'b001000000,
    S_CCLR = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  nbr_t   nbr_r, nbr_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    nbr_nxt   = nbr_r;
    cmd       = '0;
    cmd.nbr_sel = NBR_CENTER;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        nbr_nxt = NBR_CENTER;
        unique case (sts.op)
          CMD_WRITE: state_nxt = S_WR;
          CMD_STEP:  state_nxt = S_RD;
          CMD_READ:  state_nxt = S_CRD;
          CMD_NOP:   state_nxt = S_FIN;
        endcase
      end
      S_WR: begin
        cmd.spin_wr = 1'b1;
        state_nxt   = S_FIN;
      end
      S_RD: begin
        cmd.spin_rd = 1'b1;
        cmd.nbr_sel = nbr_r;
        cmd.cnt_rd  = (nbr_r == NBR_CENTER);
        if (nbr_r == NBR_RIGHT) begin
          state_nxt = S_EVAL;
        end else begin
          nbr_nxt = nbr_t'(nbr_r + 3'd1);
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_FIN;
      end
      S_CRD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_CCLR;
      end
      S_CCLR: begin
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nbr_r       <= NBR_CENTER;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nbr_r       <= nbr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DIV)
    else $error("accepted word did not start address reduction");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not presented");

endmodule

// File: hw/rtl/imsu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_dp
// Datapath of the spin update block: word capture, site reduction,
// neighbor addressing, lattice memory, counter memory, acceptance test
// and result registers.
// ----------------------------------------------------------------------------
module imsu_dp
  import imsu_pkg::*;
#(
  parameter int LATTICE_SIDE = LATTICE_SIDE_DEF,
  parameter int NUM_REPLICAS = NUM_REPLICAS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int SITES   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int REP_W   = (NUM_REPLICAS > 1) ? $clog2(NUM_REPLICAS) : 1;
  localparam int ADDR_W  = $clog2(NUM_REPLICAS * SITES);
  localparam int SOFF_W  = $clog2(SITES);
  localparam int OW      = SOFF_W + 1;
  localparam rep_tab_t REP_TAB = rep_table(NUM_REPLICAS);

  localparam logic [OW-1:0]     SIDE_O  = OW'(LATTICE_SIDE);
  localparam logic [OW-1:0]     SITES_O = OW'(SITES);
  localparam logic [SITE_W-1:0] COL_MAX = SITE_W'(LATTICE_SIDE - 1);

  // captured word
  cmd_t              op_r;
  logic [REP_W-1:0]  rep_r;
  logic [SITE_W-1:0] site_r;
  logic              wval_r;
  logic [PROB_W-1:0] rnd_r;
  logic [PROB_W-1:0] th4_r;
  logic [PROB_W-1:0] th8_r;

  logic [SITE_W-1:0] rem_s, rem_c;
  logic [SITE_W-1:0] site_mod_r;
  logic [SITE_W-1:0] col_r;
  logic [ADDR_W-1:0] base_r;

  logic [OW-1:0]     pos;
  logic [OW-1:0]     loc;
  logic [ADDR_W-1:0] spin_addr;
  logic              spin_we;
  logic              spin_wd;

  logic spin_mem [NUM_REPLICAS*SITES];
  logic spin_q_r;
  logic rd_pend_r;
  nbr_t rd_sel_r;
  logic center_r, up_r, down_r, left_r;

  logic [CNT_WORD_W-1:0] cnt_mem [NUM_REPLICAS];
  logic [NUM_REPLICAS-1:0] cnt_vld_r;
  logic [CNT_WORD_W-1:0] cnt_q_r;
  logic                  cnt_q_vld_r;
  logic [CNT_WORD_W-1:0] cnt_cur;
  logic [CNT_WORD_W-1:0] cnt_new;

  logic [3:0]            diff_bits;
  logic [2:0]            diff;
  logic                  up_move;
  logic                  acc;
  logic [PROB_W-1:0]     thr;
  logic signed [DE_W-1:0] de;

  logic [OUT_DATA_W-1:0] res_r;
  logic [OUT_DATA_W-1:0] out_r;

  assign sts.op = op_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= cmd_t'(in_tuser);
      rep_r  <= REP_TAB[in_tdata[REP_IN_W-1:0]][REP_W-1:0];
      site_r <= in_tdata[13:4];
      wval_r <= in_tdata[14];
      rnd_r  <= in_tdata[30:15];
      th4_r  <= in_tdata[46:31];
      th8_r  <= in_tdata[62:47];
    end
  end

  imsu_cmod #(.DIVISOR(SITES)) u_mod_site (
    .clk (clk),
    .x   (site_r),
    .rem (rem_s)
  );

  imsu_cmod #(.DIVISOR(LATTICE_SIDE)) u_mod_col (
    .clk (clk),
    .x   (site_r),
    .rem (rem_c)
  );

  always_ff @(posedge clk) begin
    site_mod_r <= rem_s;
    col_r      <= rem_c;
    base_r     <= ADDR_W'(rep_r * SITES);
  end

  // periodic neighbor offsets within the replica
  always_comb begin
    pos = OW'(site_mod_r);
    unique case (cmd.nbr_sel)
      NBR_CENTER: loc = pos;
      NBR_UP:     loc = (pos < SIDE_O) ? pos + SITES_O - SIDE_O : pos - SIDE_O;
      NBR_DOWN:   loc = (pos >= SITES_O - SIDE_O) ? pos + SIDE_O - SITES_O
                                                  : pos + SIDE_O;
      NBR_LEFT:   loc = (col_r == '0) ? pos + SIDE_O - OW'(1) : pos - OW'(1);
      NBR_RIGHT:  loc = (col_r == COL_MAX) ? pos - SIDE_O + OW'(1) : pos + OW'(1);
      default:    loc = pos;
    endcase
    spin_addr = base_r + ADDR_W'(loc[SOFF_W-1:0]);
  end

  // acceptance test
  always_comb begin
    diff_bits = {spin_q_r, left_r, down_r, up_r} ^ {4{center_r}};
    diff      = 3'($countones(diff_bits));
    up_move   = (diff >= 3'd3);
    thr       = (diff == 3'd3) ? th4_r : th8_r;
    acc       = !up_move || (rnd_r < thr);
    de        = $signed(DE_W'({diff, 2'b00}) - DE_W'(8));
  end

  assign spin_we = cmd.spin_wr || (cmd.eval && acc);
  assign spin_wd = cmd.eval ? ~center_r : wval_r;

  always_ff @(posedge clk) begin
    if (spin_we) begin
      spin_mem[spin_addr] <= spin_wd;
    end
    if (cmd.spin_rd) begin
      spin_q_r <= spin_mem[spin_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.spin_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_sel_r <= cmd.nbr_sel;
    if (rd_pend_r) begin
      unique case (rd_sel_r)
        NBR_CENTER: center_r <= spin_q_r;
        NBR_UP:     up_r     <= spin_q_r;
        NBR_DOWN:   down_r   <= spin_q_r;
        NBR_LEFT:   left_r   <= spin_q_r;
        default: begin
        end
      endcase
    end
  end

  // counters, read as zero until written after reset or a clear
  assign cnt_cur = cnt_q_vld_r ? cnt_q_r : '0;

  always_comb begin
    cnt_new = cnt_cur;
    cnt_new[3*CNT_W-1:2*CNT_W] = sat_inc(cnt_cur[3*CNT_W-1:2*CNT_W]);
    if (acc && up_move) begin
      cnt_new[2*CNT_W-1:CNT_W] = sat_inc(cnt_cur[2*CNT_W-1:CNT_W]);
    end
    if (acc && !up_move) begin
      cnt_new[CNT_W-1:0] = sat_inc(cnt_cur[CNT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cnt_mem[rep_r] <= cnt_new;
    end
    if (cmd.cnt_rd) begin
      cnt_q_r     <= cnt_mem[rep_r];
      cnt_q_vld_r <= cnt_vld_r[rep_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cmd.eval) begin
      cnt_vld_r[rep_r] <= 1'b1;
    end else if (cmd.cnt_clr) begin
      cnt_vld_r[rep_r] <= 1'b0;
    end
  end

  // result word: new_spin, accepted, uphill, energy_change, counts
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_r <= '0;
    end else if (cmd.spin_wr) begin
      res_r[0] <= wval_r;
    end else if (cmd.eval) begin
      res_r[0]   <= center_r ^ acc;
      res_r[1]   <= acc;
      res_r[2]   <= up_move;
      res_r[7:3] <= de;
    end else if (cmd.cnt_clr) begin
      res_r[OUT_DATA_W-1:8] <= cnt_cur;
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_tdata = out_r;

  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.spin_rd && spin_we))
    else $error("lattice read and write in one cycle");

  a_eval_after_right: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> $past(cmd.spin_rd) && ($past(cmd.nbr_sel) == NBR_RIGHT))
    else $error("evaluation without the last neighbor read");

  a_clear_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_clr |-> $past(cmd.cnt_rd))
    else $error("counter clear without preceding read");

endmodule
